>>> sv/grid_cell_and_neighbour_index_macros.svh
// Assertion macros used by the port-level checker file
`ifndef GRID_CELL_AND_NEIGHBOUR_INDEX_MACROS_SVH
`define GRID_CELL_AND_NEIGHBOUR_INDEX_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define GCNI_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("gcni check failed");
// next-cycle implication
`define GCNI_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("gcni check failed");
`endif

>>> sv/gcni_pkg.sv
// Shared constants, types and helpers for the grid cell locator
package gcni_pkg;
    localparam int COORD_BITS    = 32;
    localparam int MAX_GRID_SIZE = 1024;
    localparam int IDX_BITS      = $clog2(MAX_GRID_SIZE);
    localparam int N_BITS        = IDX_BITS + 1;
    localparam int CELL_BITS     = 30;
    localparam int DIFF_BITS     = COORD_BITS + 1;
    localparam int NUM_BITS      = DIFF_BITS + IDX_BITS;
    // dividend 2*num+den and divisor 2*den
    localparam int DVD_BITS      = NUM_BITS + 3;
    localparam int DVS_BITS      = DIFF_BITS + 1;
    localparam int QDEPTH        = 4;
    localparam int QPTR_BITS     = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        WC_OWN = 3'd0, WC_XM = 3'd1, WC_XP = 3'd2, WC_YM = 3'd3,
        WC_YP = 3'd4, WC_ZM = 3'd5, WC_ZP = 3'd6, WC_NONE = 3'd7
    } which_t;

    localparam logic [2:0] REG_MIN_X = 3'd0;
    localparam logic [2:0] REG_MAX_X = 3'd1;
    localparam logic [2:0] REG_MIN_Y = 3'd2;
    localparam logic [2:0] REG_MAX_Y = 3'd3;
    localparam logic [2:0] REG_MIN_Z = 3'd4;
    localparam logic [2:0] REG_MAX_Z = 3'd5;
    localparam logic [2:0] REG_GRID  = 3'd6;

    typedef struct packed {
        logic                mode;
        logic [IDX_BITS-1:0] ix;
        logic [IDX_BITS-1:0] iy;
        logic [IDX_BITS-1:0] iz;
    } cell_entry_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] min_x;
        logic signed [COORD_BITS-1:0] max_x;
        logic signed [COORD_BITS-1:0] min_y;
        logic signed [COORD_BITS-1:0] max_y;
        logic signed [COORD_BITS-1:0] min_z;
        logic signed [COORD_BITS-1:0] max_z;
        logic [N_BITS-1:0]            n;
    } grid_cfg_t;
endpackage

>>> sv/grid_cell_and_neighbour_index.sv
// Top level of the uniform grid cell and face-neighbour locator
//  channel | dir | contents
//  s_axis  | in  | tdata: pos_x, pos_y, pos_z; tuser: mode
//  m_axis  | out | tdata: cell_index, which_cell; tlast: last
//  apb     | in  | box_min/max x,y,z at 0x00..0x14, grid_size at 0x18
// One result word per cycle while tready is high; an item gives 1 word (mode 0) or 4..7 (mode 1).
// The front has two setup stages, 48 divider stages and an index register.
// Each result word then passes the queue, back stages A and B and the output register.
// Input is held off while the queue is full, the front has a word for it and no entry is popped.
// Reset clears all handshake state and loads the default box and grid size.
module grid_cell_and_neighbour_index
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // pos_x, pos_y, pos_z
    input  logic         s_axis_tuser,   // mode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata,   // cell_index[29:0], which_cell[32:30], zero pad
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int CW = gcni_pkg::COORD_BITS;
    localparam int NB = gcni_pkg::N_BITS;

    logic signed [CW-1:0] r_reg [6];
    logic [10:0]          gs_reg;
    gcni_pkg::grid_cfg_t  cfg;
    logic [NB-1:0]        n_eff;

    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg[0] <= '0;
            r_reg[1] <= CW'(65536);
            r_reg[2] <= '0;
            r_reg[3] <= CW'(65536);
            r_reg[4] <= '0;
            r_reg[5] <= CW'(65536);
            gs_reg   <= 11'd2;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[4:2] == gcni_pkg::REG_GRID)
                gs_reg <= pwdata[10:0];
            else if (paddr[4:2] < gcni_pkg::REG_GRID)
                r_reg[paddr[4:2]] <= pwdata;
        end
    end

    always_comb
    begin
        if (paddr[4:2] == gcni_pkg::REG_GRID)
            prdata = 32'(gs_reg);
        else if (paddr[4:2] < gcni_pkg::REG_GRID)
            prdata = r_reg[paddr[4:2]];
        else
            prdata = '0;
    end

    always_comb
    begin
        if (gs_reg < 11'd2)
            n_eff = NB'(2);
        else if (gs_reg > 11'(gcni_pkg::MAX_GRID_SIZE))
            n_eff = NB'(gcni_pkg::MAX_GRID_SIZE);
        else
            n_eff = NB'(gs_reg);
    end

    assign cfg.min_x = r_reg[gcni_pkg::REG_MIN_X];
    assign cfg.max_x = r_reg[gcni_pkg::REG_MAX_X];
    assign cfg.min_y = r_reg[gcni_pkg::REG_MIN_Y];
    assign cfg.max_y = r_reg[gcni_pkg::REG_MAX_Y];
    assign cfg.min_z = r_reg[gcni_pkg::REG_MIN_Z];
    assign cfg.max_z = r_reg[gcni_pkg::REG_MAX_Z];
    assign cfg.n     = n_eff;

    // front pipeline stalls when the queue is full, its head would land and nothing is popped
    logic                  f_valid, f_busy, q_pop, q_empty, f_stall;
    gcni_pkg::cell_entry_t f_entry, q_data;
    logic [gcni_pkg::QPTR_BITS:0] q_count;

    assign f_stall       = f_valid && (q_count == (gcni_pkg::QPTR_BITS+1)'(gcni_pkg::QDEPTH))
                           && !q_pop;
    assign s_axis_tready = !f_stall;

    gcni_front u_front (
        .clk, .rst_n,
        .in_valid (s_axis_tvalid && s_axis_tready),
        .in_mode  (s_axis_tuser),
        .in_x     (s_axis_tdata[31:0]),
        .in_y     (s_axis_tdata[63:32]),
        .in_z     (s_axis_tdata[95:64]),
        .cfg,
        .stall    (f_stall),
        .out_valid(f_valid),
        .out_entry(f_entry),
        .busy     (f_busy)
    );

    gcni_queue u_queue (
        .clk, .rst_n,
        .wr_en  (f_valid && !f_stall),
        .wr_data(f_entry),
        .rd_en  (q_pop),
        .rd_data(q_data),
        .empty  (q_empty),
        .count  (q_count)
    );

    logic [gcni_pkg::CELL_BITS-1:0] res_cell;
    logic [2:0]                     which;
    gcni_back u_back (
        .clk, .rst_n,
        .q_empty, .q_data, .q_pop,
        .n      (n_eff),
        .m_valid(m_axis_tvalid),
        .m_ready(m_axis_tready),
        .m_cell (res_cell),
        .m_which(which),
        .m_last (m_axis_tlast)
    );

    assign m_axis_tdata = {7'b0, which, res_cell} | {39'b0, 1'b0 & f_busy};
endmodule

>>> sv/gcni_axis.sv
// One axis: scale by N-1 then pipelined restoring divide, round and clamp
module gcni_axis
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_en,
    input  logic signed [gcni_pkg::COORD_BITS-1:0]  pos,
    input  logic signed [gcni_pkg::COORD_BITS-1:0]  lo,
    input  logic signed [gcni_pkg::COORD_BITS-1:0]  hi,
    input  logic [gcni_pkg::N_BITS-1:0]             n,
    input  logic                                    stall,
    output logic [gcni_pkg::IDX_BITS-1:0]           idx
);
    localparam int DB = gcni_pkg::DIFF_BITS;
    localparam int NB = gcni_pkg::NUM_BITS;
    localparam int AB = gcni_pkg::DVD_BITS;
    localparam int BB = gcni_pkg::DVS_BITS;
    localparam int IB = gcni_pkg::IDX_BITS;
    localparam int QB = AB - 1;         // quotient bits of a non-negative dividend
    localparam int ST = QB + 3;

    // stage 0: differences
    logic signed [DB-1:0] d_reg, den_reg;
    logic [IB-1:0]        top0_reg;
    // stage 1: numerator
    logic signed [NB-1:0] num_reg;
    logic signed [DB-1:0] den1_reg;
    logic [IB-1:0]        top1_reg;
    // divider pipeline
    logic [AB-1:0]        rem_reg [ST];
    logic [QB-1:0]        q_reg   [ST];
    logic [BB-1:0]        b_reg   [ST];
    logic                 neg_reg [ST];
    logic                 zero_reg[ST];
    logic [IB-1:0]        top_reg [ST];
    logic [IB-1:0]        idx_reg;

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            d_reg    <= DB'(pos) - DB'(lo);
            den_reg  <= DB'(hi) - DB'(lo);
            top0_reg <= IB'(n - 1'b1);
            num_reg  <= NB'(d_reg) * $signed({1'b0, top0_reg});
            den1_reg <= den_reg;
            top1_reg <= top0_reg;
        end
    end

    // sign fold: a = 2*num + den with den made positive
    logic signed [AB-1:0] a_s;
    logic [BB-1:0]        b_u;
    always_comb
    begin
        if (den1_reg < 0)
        begin
            a_s = -(AB'(num_reg) <<< 1) - AB'(den1_reg);
            b_u = BB'(-(BB'(den1_reg) <<< 1));
        end
        else
        begin
            a_s = (AB'(num_reg) <<< 1) + AB'(den1_reg);
            b_u = BB'(BB'(den1_reg) <<< 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            rem_reg[0]  <= a_s[AB-1] ? '0 : a_s;
            neg_reg[0]  <= a_s[AB-1];
            zero_reg[0] <= (den1_reg == '0);
            b_reg[0]    <= b_u;
            q_reg[0]    <= '0;
            top_reg[0]  <= top1_reg;
            for (int s = 1; s < ST; s++)
            begin
                neg_reg[s]  <= neg_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
                b_reg[s]    <= b_reg[s-1];
                top_reg[s]  <= top_reg[s-1];
                if (s <= QB)
                begin
                    // one quotient bit per stage, msb first
                    if ((2*AB)'(rem_reg[s-1]) >= ((2*AB)'(b_reg[s-1]) << (QB - s)))
                    begin
                        rem_reg[s] <= AB'((2*AB)'(rem_reg[s-1])
                                      - ((2*AB)'(b_reg[s-1]) << (QB - s)));
                        q_reg[s]   <= q_reg[s-1] | (QB'(1) << (QB - s));
                    end
                    else
                    begin
                        rem_reg[s] <= rem_reg[s-1];
                        q_reg[s]   <= q_reg[s-1];
                    end
                end
                else
                begin
                    rem_reg[s] <= rem_reg[s-1];
                    q_reg[s]   <= q_reg[s-1];
                end
            end
            if (zero_reg[ST-1] || neg_reg[ST-1])
                idx_reg <= '0;
            else if (q_reg[ST-1] > QB'(top_reg[ST-1]))
                idx_reg <= top_reg[ST-1];
            else
                idx_reg <= IB'(q_reg[ST-1]);
        end
    end

    assign idx = idx_reg;
    logic unused_ok;
    assign unused_ok = in_en & rst_n;
endmodule

>>> sv/gcni_front.sv
// Front end: three axis units plus a valid pipeline that feeds the queue
module gcni_front
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_mode,
    input  logic signed [gcni_pkg::COORD_BITS-1:0] in_x,
    input  logic signed [gcni_pkg::COORD_BITS-1:0] in_y,
    input  logic signed [gcni_pkg::COORD_BITS-1:0] in_z,
    input  gcni_pkg::grid_cfg_t                    cfg,
    input  logic                                   stall,
    output logic                                   out_valid,
    output gcni_pkg::cell_entry_t                  out_entry,
    output logic                                   busy
);
    // two setup stages, QB+3 divider stages, index register
    localparam int LAT = gcni_pkg::DVD_BITS - 1 + 6;
    logic       vld_reg  [LAT];
    logic       mode_reg [LAT];
    logic [gcni_pkg::IDX_BITS-1:0] ix, iy, iz;

    gcni_axis u_ax (.clk, .rst_n, .in_en(in_valid), .pos(in_x), .lo(cfg.min_x),
        .hi(cfg.max_x), .n(cfg.n), .stall, .idx(ix));
    gcni_axis u_ay (.clk, .rst_n, .in_en(in_valid), .pos(in_y), .lo(cfg.min_y),
        .hi(cfg.max_y), .n(cfg.n), .stall, .idx(iy));
    gcni_axis u_az (.clk, .rst_n, .in_en(in_valid), .pos(in_z), .lo(cfg.min_z),
        .hi(cfg.max_z), .n(cfg.n), .stall, .idx(iz));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < LAT; s++)
                vld_reg[s] <= 1'b0;
        end
        else if (!stall)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < LAT; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            mode_reg[0] <= in_mode;
            for (int s = 1; s < LAT; s++)
                mode_reg[s] <= mode_reg[s-1];
        end
    end

    always_comb
    begin
        busy = 1'b0;
        for (int s = 0; s < LAT; s++)
            busy = busy | vld_reg[s];
    end

    assign out_valid      = vld_reg[LAT-1];
    assign out_entry.mode = mode_reg[LAT-1];
    assign out_entry.ix   = ix;
    assign out_entry.iy   = iy;
    assign out_entry.iz   = iz;
endmodule

>>> sv/gcni_queue.sv
// Small FIFO between front and back ends
module gcni_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  gcni_pkg::cell_entry_t wr_data,
    input  logic                  rd_en,
    output gcni_pkg::cell_entry_t rd_data,
    output logic                  empty,
    output logic [gcni_pkg::QPTR_BITS:0] count
);
    gcni_pkg::cell_entry_t mem_reg [gcni_pkg::QDEPTH];
    logic [gcni_pkg::QPTR_BITS-1:0] wp_reg, rp_reg;
    logic [gcni_pkg::QPTR_BITS:0]   cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= wp_reg + 1'b1;
            if (rd_en)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (gcni_pkg::QPTR_BITS+1)'(wr_en)
                       - (gcni_pkg::QPTR_BITS+1)'(rd_en);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    assign rd_data = mem_reg[rp_reg];
    assign empty   = (cnt_reg == '0);
    assign count   = cnt_reg;
endmodule

>>> sv/gcni_back.sv
// Back end: walks own cell and face neighbours, one result word per cycle while m_ready allows
module gcni_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  gcni_pkg::cell_entry_t        q_data,
    output logic                         q_pop,
    input  logic [gcni_pkg::N_BITS-1:0]  n,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [gcni_pkg::CELL_BITS-1:0] m_cell,
    output logic [2:0]                   m_which,
    output logic                         m_last
);
    localparam int IB = gcni_pkg::IDX_BITS;
    localparam int CB = gcni_pkg::CELL_BITS;

    // stage A: precompute N*iy and N*N
    logic            a_vld_reg;
    logic            a_mode_reg;
    logic [IB-1:0]   a_ix_reg, a_iy_reg, a_iz_reg;
    logic [CB-1:0]   a_nn_reg;
    logic [CB-1:0]   a_ny_reg;
    // stage B: base cell ready, walking which_cell
    logic            b_vld_reg;
    logic            b_mode_reg;
    logic [IB-1:0]   b_ix_reg, b_iy_reg, b_iz_reg;
    logic [CB-1:0]   b_base_reg, b_n_reg, b_nn_reg;
    logic [2:0]      b_wc_reg;
    logic [IB-1:0]   top;

    logic            o_vld_reg;
    logic [CB-1:0]   o_cell_reg;
    logic [2:0]      o_wc_reg;
    logic            o_last_reg;

    assign top = IB'(n - 1'b1);

    // eligibility of each code for the current item
    logic [6:0] ok;
    always_comb
    begin
        ok[0] = 1'b1;
        ok[1] = b_mode_reg && (b_ix_reg != '0);
        ok[2] = b_mode_reg && (b_ix_reg != top);
        ok[3] = b_mode_reg && (b_iy_reg != '0);
        ok[4] = b_mode_reg && (b_iy_reg != top);
        ok[5] = b_mode_reg && (b_iz_reg != '0);
        ok[6] = b_mode_reg && (b_iz_reg != top);
    end

    logic [2:0] nxt_wc;
    logic       has_nxt;
    always_comb
    begin
        nxt_wc  = gcni_pkg::WC_NONE;
        has_nxt = 1'b0;
        for (int k = 6; k >= 1; k--)
        begin
            if (ok[k] && (3'(k) > b_wc_reg))
            begin
                nxt_wc  = 3'(k);
                has_nxt = 1'b1;
            end
        end
    end

    logic [CB-1:0] nb_cell;
    always_comb
    begin
        unique case (b_wc_reg)
            gcni_pkg::WC_XM: nb_cell = b_base_reg - 1'b1;
            gcni_pkg::WC_XP: nb_cell = b_base_reg + 1'b1;
            gcni_pkg::WC_YM: nb_cell = b_base_reg - b_n_reg;
            gcni_pkg::WC_YP: nb_cell = b_base_reg + b_n_reg;
            gcni_pkg::WC_ZM: nb_cell = b_base_reg - b_nn_reg;
            gcni_pkg::WC_ZP: nb_cell = b_base_reg + b_nn_reg;
            default:         nb_cell = b_base_reg;
        endcase
    end

    logic o_free, b_adv, b_done, b_load, a_load;
    assign o_free = !o_vld_reg || m_ready;
    assign b_adv  = b_vld_reg && o_free;
    assign b_done = b_adv && !has_nxt;
    assign b_load = a_vld_reg && (!b_vld_reg || b_done);
    assign a_load = !q_empty && (!a_vld_reg || b_load);
    assign q_pop  = a_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else
        begin
            if (a_load)
                a_vld_reg <= 1'b1;
            else if (b_load)
                a_vld_reg <= 1'b0;
            if (b_load)
                b_vld_reg <= 1'b1;
            else if (b_done)
                b_vld_reg <= 1'b0;
            if (b_adv)
                o_vld_reg <= 1'b1;
            else if (m_ready)
                o_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_mode_reg <= q_data.mode;
            a_ix_reg   <= q_data.ix;
            a_iy_reg   <= q_data.iy;
            a_iz_reg   <= q_data.iz;
            a_ny_reg   <= CB'(n * q_data.iy);
            a_nn_reg   <= CB'(n * n);
        end
        if (b_load)
        begin
            b_mode_reg <= a_mode_reg;
            b_ix_reg   <= a_ix_reg;
            b_iy_reg   <= a_iy_reg;
            b_iz_reg   <= a_iz_reg;
            b_base_reg <= CB'(a_ix_reg) + a_ny_reg + CB'(a_nn_reg * a_iz_reg);
            b_n_reg    <= CB'(n);
            b_nn_reg   <= a_nn_reg;
            b_wc_reg   <= gcni_pkg::WC_OWN;
        end
        else if (b_adv)
            b_wc_reg <= nxt_wc;
        if (b_adv)
        begin
            o_cell_reg <= nb_cell;
            o_wc_reg   <= b_wc_reg;
            o_last_reg <= !has_nxt;
        end
    end

    assign m_valid = o_vld_reg;
    assign m_cell  = o_cell_reg;
    assign m_which = o_wc_reg;
    assign m_last  = o_last_reg;
endmodule

>>> sv/gcni_checker.sv
// Port-level checker for the grid cell locator, bound to the top level
`include "grid_cell_and_neighbour_index_macros.svh"
module gcni_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        pready
);
    `GCNI_ASSERT_IMP(a_pready, clk, rst_n, 1'b1, pready)
    `GCNI_ASSERT_IMP(a_which_ok, clk, rst_n, m_axis_tvalid, m_axis_tdata[32:30] != 3'd7)
    `GCNI_ASSERT_IMP(a_pad_zero, clk, rst_n, m_axis_tvalid, m_axis_tdata[39:33] == 7'd0)
    `GCNI_ASSERT_NXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
endmodule

bind grid_cell_and_neighbour_index gcni_checker u_gcni_checker (
    .clk, .rst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .pready
);

>>> tb/grid_cell_and_neighbour_index_test.sv
// Testbench for the grid cell and face-neighbour locator
module grid_cell_and_neighbour_index_test;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 120;

    typedef struct {
        logic [29:0]      cidx;
        gcni_pkg::which_t which;
        logic             last;
    } cell_word_t;

    class cell_scoreboard;
        logic signed [31:0] box_lo[3];
        logic signed [31:0] box_hi[3];
        logic [10:0]        grid;
        cell_word_t         pending[$];
        int                 mismatches;

        function new();
            for (int a = 0; a < 3; a++)
            begin
                box_lo[a] = 0;
                box_hi[a] = 32'sd65536;
            end
            grid = 11'd2;
            mismatches = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] v);
            if (idx == gcni_pkg::REG_GRID)
                grid = v[10:0];
            else if (idx[0])
                box_hi[idx >> 1] = v;
            else
                box_lo[idx >> 1] = v;
        endfunction

        // round half up of (v-lo)*(n-1)/(hi-lo), clamped to the grid
        function int axis_cell(longint v, longint lo, longint hi, int n);
            longint den, num, a, b, q;
            den = hi - lo;
            if (den == 0)
                return 0;
            num = (v - lo) * (n - 1);
            if (den < 0)
            begin
                den = -den;
                num = -num;
            end
            a = 2 * num + den;
            b = 2 * den;
            q = a / b;
            if ((a % b) != 0 && a < 0)
                q = q - 1;
            if (q < 0)
                return 0;
            if (q > n - 1)
                return n - 1;
            return int'(q);
        endfunction

        function logic [29:0] linear(int ix, int iy, int iz, int n);
            longint t;
            t = ix + longint'(n) * iy + longint'(n) * n * iz;
            return t[29:0];
        endfunction

        function void add_word(cell_word_t e);
            pending = {pending, e};
        endfunction

        function void note_item(logic mode, logic signed [31:0] px,
                                logic signed [31:0] py, logic signed [31:0] pz);
            int n, top, ix, iy, iz;
            cell_word_t e;
            n = grid < 2 ? 2 : (grid > gcni_pkg::MAX_GRID_SIZE ? gcni_pkg::MAX_GRID_SIZE : grid);
            top = n - 1;
            ix = axis_cell(px, box_lo[0], box_hi[0], n);
            iy = axis_cell(py, box_lo[1], box_hi[1], n);
            iz = axis_cell(pz, box_lo[2], box_hi[2], n);
            e.last = 1'b0;
            e.cidx = linear(ix, iy, iz, n);
            e.which = gcni_pkg::WC_OWN;
            add_word(e);
            if (mode)
            begin
                if (ix > 0)
                begin
                    e.cidx = linear(ix - 1, iy, iz, n);
                    e.which = gcni_pkg::WC_XM;
                    add_word(e);
                end
                if (ix < top)
                begin
                    e.cidx = linear(ix + 1, iy, iz, n);
                    e.which = gcni_pkg::WC_XP;
                    add_word(e);
                end
                if (iy > 0)
                begin
                    e.cidx = linear(ix, iy - 1, iz, n);
                    e.which = gcni_pkg::WC_YM;
                    add_word(e);
                end
                if (iy < top)
                begin
                    e.cidx = linear(ix, iy + 1, iz, n);
                    e.which = gcni_pkg::WC_YP;
                    add_word(e);
                end
                if (iz > 0)
                begin
                    e.cidx = linear(ix, iy, iz - 1, n);
                    e.which = gcni_pkg::WC_ZM;
                    add_word(e);
                end
                if (iz < top)
                begin
                    e.cidx = linear(ix, iy, iz + 1, n);
                    e.which = gcni_pkg::WC_ZP;
                    add_word(e);
                end
            end
            pending[pending.size()-1].last = 1'b1;
        endfunction

        function void check_word(logic [29:0] got_cell, logic [2:0] which, logic last);
            cell_word_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: cell %0d which %0d last %0b",
                             got_cell, which, last);
                return;
            end
            e = pending.pop_front();
            if (got_cell !== e.cidx || which !== e.which || last !== e.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected cell %0d which %0d last %0b, got %0d %0d %0b",
                             e.cidx, e.which, e.last, got_cell, which, last);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    cell_scoreboard sb = new();
    bit no_idle = 1'b0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int stall_cycles = 0;

    grid_cell_and_neighbour_index u_top (.*);

    always #2 clk = ~clk;

    // result side: check, random backpressure, long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata[29:0], m_axis_tdata[32:30], m_axis_tlast);
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 22);
        if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) || psel)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("grid_cell_and_neighbour_index verification failed");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.write_reg(idx, v);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_box(int axis, logic [31:0] lo, logic [31:0] hi);
        write_reg(3'(2 * axis), lo);
        write_reg(3'(2 * axis + 1), hi);
    endtask

    task automatic send_item(logic mode, logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {pz, py, px};
        s_axis_tuser <= mode;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_item(mode, px, py, pz);
        if (!no_idle && $urandom_range(0, 99) < 22)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
    endtask

    // coordinate mostly inside the box, landing near cell boundaries too
    function automatic logic [31:0] pick_coord(int axis);
        longint lo, hi, v;
        lo = sb.box_lo[axis];
        hi = sb.box_hi[axis];
        if ($urandom_range(0, 99) < 25)
            return $urandom;
        v = lo + (hi - lo) * longint'($urandom_range(0, 1024)) / 1024
            + longint'($urandom_range(0, 6)) - 3;
        return v[31:0];
    endfunction

    task automatic random_config();
        int k;
        logic [31:0] lo, hi;
        for (int a = 0; a < 3; a++)
        begin
            k = $urandom_range(0, 5);
            lo = $urandom;
            hi = $urandom;
            case (k)
                0: begin lo = 32'h8000_0000; hi = 32'h7fff_ffff; end
                1: begin lo = 32'hfff0_0000; hi = 32'h0010_0000; end
                2: hi = lo;
                3: begin lo = 32'h0002_0000; hi = 32'hfffe_0000; end
                4: hi = lo + $urandom_range(1, 5000);
                default: ;
            endcase
            set_box(a, lo, hi);
        end
        case ($urandom_range(0, 5))
            0: write_reg(gcni_pkg::REG_GRID, 32'd1024);
            1: write_reg(gcni_pkg::REG_GRID, 32'd2);
            2: write_reg(gcni_pkg::REG_GRID, $urandom_range(1025, 2047));
            3: write_reg(gcni_pkg::REG_GRID, $urandom_range(0, 1));
            default: write_reg(gcni_pkg::REG_GRID, $urandom_range(3, 64));
        endcase
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default box [0,1], N = 2: extremes, exact half, just under half
        send_item(1'b0, 32'h0000_0000, 32'h0001_0000, 32'h0000_8000);
        send_item(1'b1, 32'h0000_7fff, 32'h0000_8000, 32'h0000_0000);
        send_item(1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
        send_item(1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
        send_item(1'b1, 32'hffff_ffff, 32'h0000_ffff, 32'h0000_8001);
        wait_drain();

        // full range box, N = 1024; degenerate y; inverted z
        set_box(0, 32'h8000_0000, 32'h7fff_ffff);
        set_box(1, 32'h0003_0000, 32'h0003_0000);
        set_box(2, 32'h0004_0000, 32'hfffc_0000);
        write_reg(gcni_pkg::REG_GRID, 32'd1024);
        send_item(1'b1, 32'h8000_0000, 32'h0000_0000, 32'h0004_0000);
        send_item(1'b1, 32'h7fff_ffff, 32'h7fff_ffff, 32'hfffc_0000);
        send_item(1'b1, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000);
        send_item(1'b0, 32'h0040_0000, 32'h1234_5678, 32'h0001_0000);
        send_item(1'b1, 32'hc000_0000, 32'h0003_0000, 32'h7fff_ffff);
        wait_drain();

        // grid size below and above range
        write_reg(gcni_pkg::REG_GRID, 32'd0);
        send_item(1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_item(1'b1, 32'h7fff_ffff, 32'h0000_0000, 32'h8000_0000);
        wait_drain();
        write_reg(gcni_pkg::REG_GRID, 32'h7ff);
        send_item(1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_item(1'b1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        wait_drain();

        for (int phase = 0; phase < 7; phase++)
        begin
            random_config();
            no_idle = (phase == 3);
            for (int i = 0; i < 50; i++)
            begin
                if (phase == 2 && i == 5)
                    hold_req = 1'b1;
                send_item($urandom_range(0, 99) < 70, pick_coord(0), pick_coord(1),
                          pick_coord(2));
            end
            no_idle = 1'b0;
            wait_drain();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("grid_cell_and_neighbour_index verification clean");
        else
            $display("grid_cell_and_neighbour_index verification failed");
        $finish;
    end
endmodule
